// ----- src/png_chunk_idat_xor_unscrambler_defines.svh -----
// assertion macros for the idat unscrambler
`ifndef PNG_CHUNK_IDAT_XOR_UNSCRAMBLER_DEFINES_SVH
`define PNG_CHUNK_IDAT_XOR_UNSCRAMBLER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define PNGXOR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define PNGXOR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define PNGXOR_ASSERT_NOW(label, clk, rst, ante, cons)
`define PNGXOR_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- src/pngxor_pkg.sv -----
`timescale 1ns / 1ps

package pngxor_pkg;

  localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
  localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;
  localparam logic [7:0]  KEY_RESET = 8'hE8;

  typedef enum logic [2:0] {
    PH_SIG  = 3'd0,
    PH_LEN  = 3'd1,
    PH_TYPE = 3'd2,
    PH_PAY  = 3'd3,
    PH_CRC  = 3'd4,
    PH_DONE = 3'd5
  } phase_t;

endpackage

// ----- src/png_chunk_idat_xor_unscrambler.sv -----
`timescale 1ns / 1ps
// channel   signals                                   direction
// input     in_valid, in_ready, in_byte, start_of_file  in (ready out)
// output    out_valid, out_ready, out_byte,           out (ready in)
//           in_idat_payload, finished
// config    cfg_valid, cfg_ready, cfg_data            in (ready out)
//
// one word in, one word out, one word per cycle sustained while out_ready is high
// the result is registered: parse update and xor sit before the output register
// a new word is taken whenever the output register is empty or is being
// drained in the same cycle, so a stall on out_ready stalls the input
// rst is synchronous and puts the parser in the signature phase, key = 0xE8
// cfg_ready is always high; the user must change the key only while the block is idle, the block does not enforce it

`include "png_chunk_idat_xor_unscrambler_defines.svh"

module png_chunk_idat_xor_unscrambler (
  input  logic       clk,
  input  logic       rst,
  // input words
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       start_of_file,
  // result words
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       in_idat_payload,
  output logic       finished,
  // key register
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);
  import pngxor_pkg::*;

  // parser state
  phase_t      phase;
  logic [2:0]  field_byte_count;
  logic [31:0] length_shift;
  logic [31:0] type_shift;
  logic [31:0] payload_remaining;
  logic        idat_flag;
  logic [7:0]  xor_key;

  // state as seen by the current word, after a start mark clears it
  phase_t      cur_phase;
  logic [2:0]  cur_count;
  logic [31:0] cur_length;
  logic [31:0] cur_type;
  logic [31:0] cur_remaining;
  logic        cur_idat;

  // next-state values
  phase_t      phase_next;
  logic [2:0]  field_byte_count_next;
  logic [31:0] length_shift_next;
  logic [31:0] type_shift_next;
  logic [31:0] payload_remaining_next;
  logic        idat_flag_next;

  // result values
  logic [7:0]  out_byte_next;
  logic        xored_next;

  logic [2:0]  count_inc;
  logic [31:0] length_in;
  logic [31:0] type_in;
  logic [31:0] remaining_dec;
  logic        in_accept;

  // output register empty or draining this cycle
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // a start mark restarts the parse at signature byte 0
  always_comb begin
    if (start_of_file) begin
      cur_phase     = PH_SIG;
      cur_count     = 3'd0;
      cur_length    = 32'd0;
      cur_type      = 32'd0;
      cur_remaining = 32'd0;
      cur_idat      = 1'b0;
    end else begin
      cur_phase     = phase;
      cur_count     = field_byte_count;
      cur_length    = length_shift;
      cur_type      = type_shift;
      cur_remaining = payload_remaining;
      cur_idat      = idat_flag;
    end
  end

  assign count_inc     = cur_count + 3'd1;
  assign length_in     = {cur_length[23:0], in_byte};
  assign type_in       = {cur_type[23:0], in_byte};
  assign remaining_dec = cur_remaining - 32'd1;

  // next-state logic
  always_comb begin
    phase_next             = cur_phase;
    field_byte_count_next  = cur_count;
    length_shift_next      = cur_length;
    type_shift_next        = cur_type;
    payload_remaining_next = cur_remaining;
    idat_flag_next         = cur_idat;
    unique case (cur_phase)
      PH_SIG: begin
        // eight signature bytes, counter wraps to zero on the last one
        field_byte_count_next = count_inc;
        if (count_inc == 3'd0) begin
          phase_next = PH_LEN;
        end
      end
      PH_LEN: begin
        length_shift_next     = length_in;
        field_byte_count_next = count_inc;
        if (count_inc[2]) begin
          field_byte_count_next  = 3'd0;
          payload_remaining_next = length_in;
          phase_next             = PH_TYPE;
        end
      end
      PH_TYPE: begin
        type_shift_next       = type_in;
        field_byte_count_next = count_inc;
        if (count_inc[2]) begin
          field_byte_count_next = 3'd0;
          if (type_in == TYPE_IEND) begin
            idat_flag_next = 1'b0;
            phase_next     = PH_DONE;
          end else begin
            idat_flag_next = (type_in == TYPE_IDAT);
            // empty chunk skips straight to its crc
            phase_next     = (cur_remaining == 32'd0) ? PH_CRC : PH_PAY;
          end
        end
      end
      PH_PAY: begin
        payload_remaining_next = remaining_dec;
        if (remaining_dec == 32'd0) begin
          phase_next = PH_CRC;
        end
      end
      PH_CRC: begin
        field_byte_count_next = count_inc;
        if (count_inc[2]) begin
          field_byte_count_next = 3'd0;
          length_shift_next     = 32'd0;
          type_shift_next       = 32'd0;
          idat_flag_next        = 1'b0;
          phase_next            = PH_LEN;
        end
      end
      PH_DONE: begin
        // everything after the end chunk type passes through
      end
      default: begin
      end
    endcase
  end

  // result logic: only idat payload bytes are scrambled
  always_comb begin
    out_byte_next = in_byte;
    xored_next    = 1'b0;
    if (cur_phase == PH_PAY && cur_idat) begin
      out_byte_next = in_byte ^ xor_key;
      xored_next    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_SIG;
      field_byte_count  <= 3'd0;
      length_shift      <= 32'd0;
      type_shift        <= 32'd0;
      payload_remaining <= 32'd0;
      idat_flag         <= 1'b0;
      xor_key           <= KEY_RESET;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        xor_key <= cfg_data;
      end
      if (in_accept) begin
        phase             <= phase_next;
        field_byte_count  <= field_byte_count_next;
        length_shift      <= length_shift_next;
        type_shift        <= type_shift_next;
        payload_remaining <= payload_remaining_next;
        idat_flag         <= idat_flag_next;
        out_valid         <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_byte        <= out_byte_next;
      in_idat_payload <= xored_next;
      finished        <= (phase_next == PH_DONE);
    end
  end

  // a scrambled byte can never come from a finished stream
  `PNGXOR_ASSERT_NOW(a_xor_not_done, clk, rst, out_valid && in_idat_payload, !finished)
  // payload phase always has bytes left to count down
  `PNGXOR_ASSERT_NOW(a_pay_nonzero, clk, rst, phase == PH_PAY, payload_remaining != 32'd0)
  // only a start mark leaves the done phase
  `PNGXOR_ASSERT_NEXT(a_done_sticks, clk, rst,
                      in_accept && !start_of_file && phase == PH_DONE, phase == PH_DONE)
  // every accepted word shows up in the output register
  `PNGXOR_ASSERT_NEXT(a_accept_fills, clk, rst, in_accept, out_valid)

endmodule
